/* hw/rtl/pgi_pkg.sv */
// Shared types and codes for the path guided impedance block.
// Used by the channel interfaces, the lanes, the merge stage and the top level.
`timescale 1ns / 1ps

package pgi_pkg;

  typedef logic [3:0] step_t;

  localparam step_t STEP_IDLE  = 4'd0;
  localparam step_t STEP_DOT   = 4'd1;
  localparam step_t STEP_VEL   = 4'd2;
  localparam step_t STEP_PROJ  = 4'd3;
  localparam step_t STEP_VPATH = 4'd4;
  localparam step_t STEP_SPR   = 4'd5;
  localparam step_t STEP_DMP   = 4'd6;
  localparam step_t STEP_AST   = 4'd7;
  localparam step_t STEP_SUM   = 4'd8;
  localparam step_t STEP_SQR   = 4'd9;
  localparam step_t STEP_NRM   = 4'd10;

  typedef logic [1:0] region_t;

  localparam region_t REGION_LOW  = 2'd0;
  localparam region_t REGION_MID  = 2'd1;
  localparam region_t REGION_HIGH = 2'd2;

  localparam int CFG_IDX_W = 3;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam cfg_idx_t CFG_END_X     = 3'd0;
  localparam cfg_idx_t CFG_END_Y     = 3'd1;
  localparam cfg_idx_t CFG_END_Z     = 3'd2;
  localparam cfg_idx_t CFG_STIFFNESS = 3'd3;
  localparam cfg_idx_t CFG_DAMPING   = 3'd4;
  localparam cfg_idx_t CFG_ASSIST    = 3'd5;

  typedef struct packed {
    step_t   step;
    region_t region;
  } lane_ctl_t;

endpackage

/* hw/rtl/pgi_if.sv */
// Channel interfaces for input items, results and configuration writes.
// Depends on pgi_pkg for the register index type.
`timescale 1ns / 1ps

interface pgi_in_if #(parameter int W = 32);
  logic         valid;
  logic         ready;
  logic [W-1:0] pos_x;
  logic [W-1:0] pos_y;
  logic [W-1:0] pos_z;
  logic [W-1:0] vel_x;
  logic [W-1:0] vel_y;
  logic [W-1:0] vel_z;
  logic         restart;
  modport source (output valid, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, restart,
                  input ready);
  modport sink (input valid, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, restart,
                output ready);
endinterface

interface pgi_out_if #(parameter int W = 32);
  logic         valid;
  logic         ready;
  logic [W-1:0] force_x;
  logic [W-1:0] force_y;
  logic [W-1:0] force_z;
  logic [W-1:0] progress;
  logic         path_degenerate;
  modport source (output valid, force_x, force_y, force_z, progress, path_degenerate,
                  input ready);
  modport sink (input valid, force_x, force_y, force_z, progress, path_degenerate,
                output ready);
endinterface

interface pgi_cfg_if import pgi_pkg::*; #(parameter int W = 32);
  logic         valid;
  logic         ready;
  cfg_idx_t     index;
  logic [W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

/* hw/rtl/pgi_lane.sv */
// One axis lane: holds the start point and direction component and runs
// one fixed-point multiply per step. Depends on pgi_pkg for step codes.
`timescale 1ns / 1ps

module pgi_lane import pgi_pkg::*; #(
  parameter int W = 32,
  parameter int F = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  lane_ctl_t             ctl_i,
  input  logic signed [W-1:0]   pos_i,
  input  logic signed [W-1:0]   vel_i,
  input  logic signed [W-1:0]   end_i,
  input  logic [W-1:0]          k_i,
  input  logic [W-1:0]          d_i,
  input  logic signed [W-1:0]   s_i,
  input  logic signed [W-1:0]   vp_i,
  input  logic signed [W-1:0]   ab_i,
  input  logic                  u_load_i,
  input  logic signed [W-1:0]   u_i,
  output logic signed [W-1:0]   dp_o,
  output logic signed [W-1:0]   vd_o,
  output logic [2*W+1:0]        sq_o,
  output logic [W:0]            diff_mag_o,
  output logic                  diff_neg_o,
  output logic signed [W-1:0]   force_o
);

  localparam logic signed [W-1:0] MAXW = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] MINW = {1'b1, {(W-1){1'b0}}};
  localparam logic [2*W+1:0] LIM_N = (2*W+2)'(1) << (W-1);
  localparam logic [2*W+1:0] LIM_P = LIM_N - (2*W+2)'(1);

  function automatic logic signed [W-1:0] sat1(input logic signed [W:0] v);
    if (v[W] != v[W-1]) return v[W] ? MINW : MAXW;
    return v[W-1:0];
  endfunction

  function automatic logic signed [W-1:0] sat2(input logic signed [W+1:0] v);
    if ((v[W+1:W-1] == 3'b000) || (v[W+1:W-1] == 3'b111)) return v[W-1:0];
    return v[W+1] ? MINW : MAXW;
  endfunction

  function automatic logic signed [W:0] ext(input logic signed [W-1:0] v);
    return {v[W-1], v};
  endfunction

  logic signed [W-1:0] start_q, u_q;
  logic signed [W-1:0] dp_q, vd_q, pj_q, vpa_q, xd_q, t1_q, t2_q, t3_q, force_q;
  logic [2*W+1:0]      sq_q;
  logic signed [W:0]   diff_q;

  logic signed [W:0]   opa, opb, diff;
  logic [W:0]          ma, mb;
  logic [2*W+1:0]      prod, sh;
  logic                neg;
  logic signed [W-1:0] mq, xd_d;

  assign diff = ext(end_i) - ext(pos_i);

  always_comb begin
    unique case (ctl_i.step)
      STEP_DOT: begin
        opa = ext(sat1(ext(pos_i) - ext(start_q)));
        opb = ext(u_q);
      end
      STEP_VEL: begin
        opa = ext(vel_i);
        opb = ext(u_q);
      end
      STEP_PROJ: begin
        opa = ext(s_i);
        opb = ext(u_q);
      end
      STEP_VPATH: begin
        opa = ext(vp_i);
        opb = ext(u_q);
      end
      STEP_SPR: begin
        opa = {1'b0, k_i};
        opb = ext(sat1(ext(xd_q) - ext(pos_i)));
      end
      STEP_DMP: begin
        opa = {1'b0, d_i};
        opb = ext(sat1(ext(vel_i) - ext(vpa_q)));
      end
      STEP_AST: begin
        opa = ext(ab_i);
        opb = ext(vpa_q);
      end
      STEP_SQR: begin
        opa = diff;
        opb = diff;
      end
      default: begin
        opa = '0;
        opb = '0;
      end
    endcase
  end

  always_comb begin
    ma   = opa[W] ? (~opa + 1'b1) : opa;
    mb   = opb[W] ? (~opb + 1'b1) : opb;
    neg  = opa[W] ^ opb[W];
    prod = (2*W+2)'(ma) * (2*W+2)'(mb);
    sh   = prod >> F;
    if (neg) begin
      mq = (sh > LIM_N) ? MINW : (~sh[W-1:0] + 1'b1);
    end else begin
      mq = (sh > LIM_P) ? MAXW : sh[W-1:0];
    end
  end

  always_comb begin
    unique case (ctl_i.region)
      REGION_LOW:  xd_d = start_q;
      REGION_HIGH: xd_d = end_i;
      default:     xd_d = sat1(ext(start_q) + ext(pj_q));
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q <= '0;
      u_q     <= '0;
    end else begin
      if (ctl_i.step == STEP_SQR) start_q <= pos_i;
      if (u_load_i) u_q <= u_i;
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (ctl_i.step)
      STEP_DOT:   dp_q <= mq;
      STEP_VEL:   vd_q <= mq;
      STEP_PROJ:  pj_q <= mq;
      STEP_VPATH: begin
        vpa_q <= mq;
        xd_q  <= xd_d;
      end
      STEP_SPR:   t1_q <= mq;
      STEP_DMP:   t2_q <= mq;
      STEP_AST:   t3_q <= mq;
      STEP_SUM:   force_q <= sat2({{2{t1_q[W-1]}}, t1_q} - {{2{t2_q[W-1]}}, t2_q}
                                  + {{2{t3_q[W-1]}}, t3_q});
      STEP_SQR: begin
        sq_q   <= prod;
        diff_q <= diff;
      end
      default: ;
    endcase
  end

  assign dp_o       = dp_q;
  assign vd_o       = vd_q;
  assign sq_o       = sq_q;
  assign diff_neg_o = diff_q[W];
  assign diff_mag_o = diff_q[W] ? (~diff_q + 1'b1) : diff_q;
  assign force_o    = force_q;

endmodule

/* hw/rtl/pgi_merge.sv */
// Merge stage: sums the lane products into path coordinate, path speed and
// squared length, and multiplies out progress and assist factor. Depends on pgi_pkg.
`timescale 1ns / 1ps

module pgi_merge import pgi_pkg::*; #(
  parameter int W = 32,
  parameter int F = 16
) (
  input  logic                 clk_i,
  input  step_t                step_i,
  input  logic signed [W-1:0]  dp_i [3],
  input  logic signed [W-1:0]  vd_i [3],
  input  logic [2*W+1:0]       sq_i [3],
  input  logic signed [W-1:0]  inv_i,
  input  logic signed [W-1:0]  assist_i,
  output logic signed [W-1:0]  s_o,
  output logic signed [W-1:0]  vp_o,
  output logic signed [W-1:0]  prog_o,
  output logic signed [W-1:0]  ab_o,
  output region_t              region_o,
  output logic [2*W+3:0]       n2_o
);

  localparam logic signed [W-1:0] MAXW = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] MINW = {1'b1, {(W-1){1'b0}}};
  localparam logic [2*W+1:0] LIM_N = (2*W+2)'(1) << (W-1);
  localparam logic [2*W+1:0] LIM_P = LIM_N - (2*W+2)'(1);
  localparam logic signed [W+1:0] ONE_E  = (W+2)'(1) << F;
  localparam logic signed [W+1:0] HALF_E = (W+2)'(1) << (F-1);

  function automatic logic signed [W-1:0] sat2(input logic signed [W+1:0] v);
    if ((v[W+1:W-1] == 3'b000) || (v[W+1:W-1] == 3'b111)) return v[W-1:0];
    return v[W+1] ? MINW : MAXW;
  endfunction

  function automatic logic signed [W+1:0] ext2(input logic signed [W-1:0] v);
    return {{2{v[W-1]}}, v};
  endfunction

  logic signed [W-1:0] s_q, vp_q, prog_q, ab_q;
  logic [2*W+3:0]      n2_q;

  logic signed [W+1:0] prog_e, b_e;
  logic signed [W-1:0] opa, opb, mq;
  logic [W:0]          ma, mb;
  logic [2*W+1:0]      prod, sh;
  logic                neg;

  assign prog_e = ext2(prog_q);

  always_comb begin
    if (prog_e <= 0) begin
      region_o = REGION_LOW;
      b_e      = '0;
    end else if (prog_e >= ONE_E) begin
      region_o = REGION_HIGH;
      b_e      = '0;
    end else begin
      region_o = REGION_MID;
      b_e      = (prog_e > HALF_E) ? (ONE_E - prog_e) : prog_e;
    end
  end

  always_comb begin
    if (step_i == STEP_PROJ) begin
      opa = s_q;
      opb = inv_i;
    end else begin
      opa = assist_i;
      opb = b_e[W-1:0];
    end
    ma   = opa[W-1] ? (~{1'b1, opa} + 1'b1) : {1'b0, opa};
    mb   = opb[W-1] ? (~{1'b1, opb} + 1'b1) : {1'b0, opb};
    neg  = opa[W-1] ^ opb[W-1];
    prod = (2*W+2)'(ma) * (2*W+2)'(mb);
    sh   = prod >> F;
    if (neg) begin
      mq = (sh > LIM_N) ? MINW : (~sh[W-1:0] + 1'b1);
    end else begin
      mq = (sh > LIM_P) ? MAXW : sh[W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (step_i)
      STEP_VEL:   s_q <= sat2(ext2(dp_i[0]) + ext2(dp_i[1]) + ext2(dp_i[2]));
      STEP_PROJ: begin
        vp_q   <= sat2(ext2(vd_i[0]) + ext2(vd_i[1]) + ext2(vd_i[2]));
        prog_q <= mq;
      end
      STEP_VPATH: ab_q <= mq;
      STEP_NRM:   n2_q <= (2*W+4)'(sq_i[0]) + (2*W+4)'(sq_i[1]) + (2*W+4)'(sq_i[2]);
      default: ;
    endcase
  end

  assign s_o    = s_q;
  assign vp_o   = vp_q;
  assign prog_o = prog_q;
  assign ab_o   = ab_q;
  assign n2_o   = n2_q;

endmodule

/* hw/rtl/pgi_root_div.sv */
// Restart solver: bit-serial integer square root of the squared length,
// then four restoring divisions for the unit direction and inverse length.
`timescale 1ns / 1ps

module pgi_root_div #(
  parameter int W = 32,
  parameter int F = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [2*W+3:0]       n2_i,
  input  logic [W:0]           mag_i [3],
  input  logic                 neg_i [3],
  output logic                 done_o,
  output logic signed [W-1:0]  u_o [3],
  output logic signed [W-1:0]  inv_o
);

  localparam int R  = W + 2;
  localparam int NB = 2 * W + 4;
  localparam int DN = W + 1 + F;
  localparam int CW = $clog2(DN + 1);

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_SQRT = 2'd1;
  localparam logic [1:0] PH_DIV  = 2'd2;

  localparam logic signed [W-1:0] MAXW = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] MINW = {1'b1, {(W-1){1'b0}}};
  localparam logic [DN-1:0] QLIM_N = DN'(1) << (W-1);
  localparam logic [DN-1:0] QLIM_P = QLIM_N - DN'(1);

  logic [1:0]          ph_q;
  logic [CW-1:0]       cnt_q;
  logic [1:0]          sel_q;
  logic                done_q;
  logic [NB-1:0]       nq_q;
  logic [R+2:0]        rem_q;
  logic [R-1:0]        root_q;
  logic [DN-1:0]       num_q, quot_q;
  logic [R:0]          drem_q;
  logic signed [W-1:0] u_q [3];
  logic signed [W-1:0] inv_q;

  logic [R+2:0]        rem_t, trial;
  logic                ge, dge, qneg;
  logic [R:0]          dr_t;
  logic [DN-1:0]       q_n, num_next;
  logic signed [W-1:0] q_sat;
  logic [1:0]          sel_next;

  assign rem_t = {rem_q[R:0], nq_q[NB-1:NB-2]};
  assign trial = {1'b0, root_q, 2'b01};
  assign ge    = rem_t >= trial;

  assign dr_t  = {drem_q[R-1:0], num_q[DN-1]};
  assign dge   = dr_t >= {1'b0, root_q};
  assign q_n   = {quot_q[DN-2:0], dge};
  assign qneg  = (sel_q == 2'd3) ? 1'b0 : neg_i[sel_q];

  always_comb begin
    if (qneg) begin
      q_sat = (q_n > QLIM_N) ? MINW : (~q_n[W-1:0] + 1'b1);
    end else begin
      q_sat = (q_n > QLIM_P) ? MAXW : q_n[W-1:0];
    end
  end

  assign sel_next = (ph_q == PH_SQRT) ? 2'd0 : (sel_q + 2'd1);
  assign num_next = (sel_next == 2'd3) ? (DN'(1) << (2 * F))
                                       : (DN'(mag_i[sel_next]) << F);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q   <= PH_IDLE;
      cnt_q  <= '0;
      sel_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      unique case (ph_q)
        PH_IDLE: begin
          if (start_i) begin
            ph_q  <= PH_SQRT;
            cnt_q <= CW'(R);
          end
        end
        PH_SQRT: begin
          if (cnt_q == CW'(1)) begin
            ph_q  <= PH_DIV;
            sel_q <= sel_next;
            cnt_q <= CW'(DN);
          end else begin
            cnt_q <= cnt_q - CW'(1);
          end
        end
        PH_DIV: begin
          if (cnt_q == CW'(1)) begin
            if (sel_q == 2'd3) begin
              ph_q   <= PH_IDLE;
              done_q <= 1'b1;
            end else begin
              sel_q <= sel_next;
              cnt_q <= CW'(DN);
            end
          end else begin
            cnt_q <= cnt_q - CW'(1);
          end
        end
        default: ph_q <= PH_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (ph_q)
      PH_IDLE: begin
        nq_q   <= n2_i;
        rem_q  <= '0;
        root_q <= '0;
      end
      PH_SQRT: begin
        nq_q   <= {nq_q[NB-3:0], 2'b00};
        rem_q  <= ge ? (rem_t - trial) : rem_t;
        root_q <= {root_q[R-2:0], ge};
        if (cnt_q == CW'(1)) begin
          num_q  <= num_next;
          drem_q <= '0;
          quot_q <= '0;
        end
      end
      PH_DIV: begin
        if (cnt_q == CW'(1)) begin
          if (sel_q == 2'd3) inv_q <= q_sat;
          else u_q[sel_q] <= q_sat;
          num_q  <= num_next;
          drem_q <= '0;
          quot_q <= '0;
        end else begin
          num_q  <= {num_q[DN-2:0], 1'b0};
          drem_q <= dge ? (dr_t - {1'b0, root_q}) : dr_t;
          quot_q <= q_n;
        end
      end
      default: ;
    endcase
  end

  assign done_o = done_q;
  assign u_o    = u_q;
  assign inv_o  = inv_q;

endmodule

/* hw/rtl/path_guided_impedance.sv */
// Top level of the path guided impedance controller.
// Depends on pgi_pkg, the channel interfaces, pgi_lane, pgi_merge and pgi_root_div.
//
// Use: one input transaction per control tick carries position, velocity and
// the restart flag; one result transaction returns force, progress and the
// degenerate flag. Configuration writes go through the cfg channel, which is
// always ready; write registers only while the block is idle.
// Sequence: a normal tick runs the three axis lanes through seven multiplies
// and a sum before the result is loaded. A tick on a degenerate path goes
// straight to the output register. A restart tick runs the bit-serial square
// root and the four restoring divisions of the solver; a restart onto a
// zero-length path skips the solver.
// Throughput: one transaction at a time; the next input is taken while the
// previous result still waits in the output register.
// Reset: all gains and end registers read zero, the path is degenerate and
// the output register is empty. A stalled receiver holds the result and the
// block stops before its next result until the register is free.
`timescale 1ns / 1ps

module path_guided_impedance import pgi_pkg::*; #(
  parameter int WORD_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  pgi_in_if.sink     in_i,
  pgi_out_if.source  out_o,
  pgi_cfg_if.sink    cfg_i
);

  localparam int W = WORD_WIDTH;
  localparam int F = FRAC_BITS;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_RUN   = 3'd1;
  localparam logic [2:0] ST_CHK   = 3'd2;
  localparam logic [2:0] ST_SOLVE = 3'd3;
  localparam logic [2:0] ST_FIN   = 3'd4;

  logic [2:0]          state_q, state_d;
  step_t               step_q, step_d;
  logic                zero_q, zero_d;
  logic                deg_q, deg_d;
  logic signed [W-1:0] inv_q, inv_d;
  logic signed [W-1:0] end_q [3];
  logic [W-1:0]        k_q, dmp_q;
  logic signed [W-1:0] assist_q;
  logic signed [W-1:0] pos_q [3];
  logic signed [W-1:0] vel_q [3];
  logic                out_v_q;
  logic [W-1:0]        fx_q, fy_q, fz_q, prog_out_q;
  logic                deg_out_q;

  logic                in_acc, fin_load, solve_start, u_load;
  lane_ctl_t           lane_ctl;
  logic signed [W-1:0] dp [3];
  logic signed [W-1:0] vd [3];
  logic [2*W+1:0]      sq [3];
  logic [W:0]          dmag [3];
  logic                dneg [3];
  logic signed [W-1:0] frc [3];
  logic signed [W-1:0] sol_u [3];
  logic signed [W-1:0] u_val [3];
  logic signed [W-1:0] s_w, vp_w, prog_w, ab_w, sol_inv;
  region_t             region_w;
  logic [2*W+3:0]      n2_w;
  logic                sol_done;

  assign in_i.ready  = (state_q == ST_IDLE);
  assign cfg_i.ready = 1'b1;
  assign in_acc      = in_i.valid && (state_q == ST_IDLE);
  assign fin_load    = (state_q == ST_FIN) && (!out_v_q || out_o.ready);

  assign lane_ctl.step   = step_q;
  assign lane_ctl.region = region_w;

  always_comb begin
    state_d     = state_q;
    step_d      = step_q;
    zero_d      = zero_q;
    deg_d       = deg_q;
    inv_d       = inv_q;
    solve_start = 1'b0;
    u_load      = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_i.restart) begin
            state_d = ST_RUN;
            step_d  = STEP_SQR;
            zero_d  = 1'b1;
          end else if (deg_q) begin
            state_d = ST_FIN;
            zero_d  = 1'b1;
          end else begin
            state_d = ST_RUN;
            step_d  = STEP_DOT;
            zero_d  = 1'b0;
          end
        end
      end
      ST_RUN: begin
        unique case (step_q)
          STEP_DOT:   step_d = STEP_VEL;
          STEP_VEL:   step_d = STEP_PROJ;
          STEP_PROJ:  step_d = STEP_VPATH;
          STEP_VPATH: step_d = STEP_SPR;
          STEP_SPR:   step_d = STEP_DMP;
          STEP_DMP:   step_d = STEP_AST;
          STEP_AST:   step_d = STEP_SUM;
          STEP_SQR:   step_d = STEP_NRM;
          STEP_NRM: begin
            step_d  = STEP_IDLE;
            state_d = ST_CHK;
          end
          default: begin
            step_d  = STEP_IDLE;
            state_d = ST_FIN;
          end
        endcase
      end
      ST_CHK: begin
        if (n2_w == '0) begin
          deg_d   = 1'b1;
          inv_d   = '0;
          u_load  = 1'b1;
          state_d = ST_FIN;
        end else begin
          solve_start = 1'b1;
          state_d     = ST_SOLVE;
        end
      end
      ST_SOLVE: begin
        if (sol_done) begin
          deg_d   = 1'b0;
          inv_d   = sol_inv;
          u_load  = 1'b1;
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        if (fin_load) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      u_val[i] = (state_q == ST_SOLVE) ? sol_u[i] : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      step_q   <= STEP_IDLE;
      zero_q   <= 1'b1;
      deg_q    <= 1'b1;
      inv_q    <= '0;
      out_v_q  <= 1'b0;
      end_q[0] <= '0;
      end_q[1] <= '0;
      end_q[2] <= '0;
      k_q      <= '0;
      dmp_q    <= '0;
      assist_q <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      zero_q  <= zero_d;
      deg_q   <= deg_d;
      inv_q   <= inv_d;
      if (fin_load) out_v_q <= 1'b1;
      else if (out_o.ready) out_v_q <= 1'b0;
      if (cfg_i.valid) begin
        unique case (cfg_i.index)
          CFG_END_X:     end_q[0] <= cfg_i.data;
          CFG_END_Y:     end_q[1] <= cfg_i.data;
          CFG_END_Z:     end_q[2] <= cfg_i.data;
          CFG_STIFFNESS: k_q      <= cfg_i.data;
          CFG_DAMPING:   dmp_q    <= cfg_i.data;
          CFG_ASSIST:    assist_q <= cfg_i.data;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      pos_q[0] <= in_i.pos_x;
      pos_q[1] <= in_i.pos_y;
      pos_q[2] <= in_i.pos_z;
      vel_q[0] <= in_i.vel_x;
      vel_q[1] <= in_i.vel_y;
      vel_q[2] <= in_i.vel_z;
    end
    if (fin_load) begin
      fx_q       <= zero_q ? '0 : frc[0];
      fy_q       <= zero_q ? '0 : frc[1];
      fz_q       <= zero_q ? '0 : frc[2];
      prog_out_q <= zero_q ? '0 : prog_w;
      deg_out_q  <= deg_q;
    end
  end

  for (genvar g = 0; g < 3; g++) begin : g_lane
    pgi_lane #(.W(W), .F(F)) u_lane (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctl_i      (lane_ctl),
      .pos_i      (pos_q[g]),
      .vel_i      (vel_q[g]),
      .end_i      (end_q[g]),
      .k_i        (k_q),
      .d_i        (dmp_q),
      .s_i        (s_w),
      .vp_i       (vp_w),
      .ab_i       (ab_w),
      .u_load_i   (u_load),
      .u_i        (u_val[g]),
      .dp_o       (dp[g]),
      .vd_o       (vd[g]),
      .sq_o       (sq[g]),
      .diff_mag_o (dmag[g]),
      .diff_neg_o (dneg[g]),
      .force_o    (frc[g])
    );
  end

  pgi_merge #(.W(W), .F(F)) u_merge (
    .clk_i    (clk_i),
    .step_i   (step_q),
    .dp_i     (dp),
    .vd_i     (vd),
    .sq_i     (sq),
    .inv_i    (inv_q),
    .assist_i (assist_q),
    .s_o      (s_w),
    .vp_o     (vp_w),
    .prog_o   (prog_w),
    .ab_o     (ab_w),
    .region_o (region_w),
    .n2_o     (n2_w)
  );

  pgi_root_div #(.W(W), .F(F)) u_root_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (solve_start),
    .n2_i    (n2_w),
    .mag_i   (dmag),
    .neg_i   (dneg),
    .done_o  (sol_done),
    .u_o     (sol_u),
    .inv_o   (sol_inv)
  );

  assign out_o.valid           = out_v_q;
  assign out_o.force_x         = fx_q;
  assign out_o.force_y         = fy_q;
  assign out_o.force_z         = fz_q;
  assign out_o.progress        = prog_out_q;
  assign out_o.path_degenerate = deg_out_q;

endmodule
